// ----- src/nls_pkg.sv -----
// ----------------------------------------------------------------------------
// nls_pkg
// shared types, codes and helpers for the numeric literal scanner
// ----------------------------------------------------------------------------
`default_nettype none

package nls_pkg;

    localparam int TOKEN_LEN_MAX = 255;
    localparam logic [7:0] LEN_CAP = 8'((TOKEN_LEN_MAX < 255) ? TOKEN_LEN_MAX : 255);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [1:0] UNC_ONE = 2'd1;
    localparam logic [1:0] UNC_TWO = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_INT  = 3'd1,
        MODE_FRAC = 3'd2,
        MODE_EXPE = 3'd3,
        MODE_SIGN = 3'd4,
        MODE_EXP  = 3'd5,
        MODE_HEX  = 3'd6
    } scan_mode_t;

    typedef enum logic [2:0] {
        CLS_INT     = 3'd0,
        CLS_FLOAT   = 3'd1,
        CLS_HEX     = 3'd2,
        CLS_ILLEGAL = 3'd3,
        CLS_NOTNUM  = 3'd4
    } token_class_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic        first_zero;
        logic        last_digit;
        logic [7:0]  count;
        logic        ovf;
    } scan_state_t;

    typedef struct packed {
        token_class_t token_class;
        logic [7:0]   token_length;
        logic [1:0]   unconsumed;
        logic         length_saturated;
    } token_result_t;

    typedef struct packed {
        logic [7:0] count;
        logic       ovf;
    } length_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic length_t count_one(input length_t l);
        length_t r;
        r = l;
        if (l.count >= LEN_CAP)
        begin
            r.ovf = 1'b1;
        end
        else
        begin
            r.count = l.count + 8'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/numeric_literal_scanner_top.sv -----
// ----------------------------------------------------------------------------
// numeric_literal_scanner_top
// scans one numeric literal from a byte stream and reports class and length
//
//   channel   dir   word                                    ends a word
//   s_axis    in    ch [7:0]                                tvalid & tready
//   m_axis    out   class, length, unconsumed, saturated    tvalid & tready
//
// one byte per cycle; a result word is registered in the cycle after its
// ending byte. the scanner state updates in the same cycle a byte is taken.
// reset clears the scanner to idle and empties the result register.
// a stalled result stops byte intake only when its register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module numeric_literal_scanner_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // ch[7:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // token_class[2:0], token_length[10:3],
                                             // unconsumed[12:11], length_saturated[13]
);
    import nls_pkg::*;

    scan_state_t   state_reg;
    scan_state_t   state_next;
    scan_state_t   step_nxt;
    logic          step_emit;
    token_result_t step_res;
    token_result_t out_res;
    logic          can_load;
    logic          in_acc;

    assign s_axis_tready = can_load;
    assign in_acc        = s_axis_tvalid && can_load;

    nls_step u_step (
        .cur  (state_reg),
        .ch   (s_axis_tdata),
        .nxt  (step_nxt),
        .emit (step_emit),
        .res  (step_res)
    );

    nls_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_acc && step_emit),
        .load_res  (step_res),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign state_next = in_acc ? step_nxt : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign m_axis_tdata = {2'b00, out_res.length_saturated, out_res.unconsumed,
                           out_res.token_length, out_res.token_class};

    a_unc_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_res.unconsumed == UNC_ONE || out_res.unconsumed == UNC_TWO))
        else $error("unconsumed out of range");

    a_notnum_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res.token_class == CLS_NOTNUM) |-> (out_res.token_length == 8'd0))
        else $error("non-numeric result with nonzero length");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && step_emit) |=> (state_reg.mode == MODE_IDLE && state_reg.count == 8'd0))
        else $error("scanner not cleared after result");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && step_emit) |=> m_axis_tvalid)
        else $error("result lost");

endmodule

`default_nettype wire

// ----- src/nls_step.sv -----
// ----------------------------------------------------------------------------
// nls_step
// per-byte next state and token result of the literal scanner
// ----------------------------------------------------------------------------
`default_nettype none

module nls_step (
    input  wire nls_pkg::scan_state_t   cur,
    input  wire logic [7:0]             ch,
    output nls_pkg::scan_state_t        nxt,
    output logic                        emit,
    output nls_pkg::token_result_t      res
);
    import nls_pkg::*;

    length_t     len_cur;
    length_t     len_one;
    length_t     len_two;
    length_t     len_first;
    token_class_t cls;
    logic [1:0]  unc;

    assign len_cur   = '{count: cur.count, ovf: cur.ovf};
    assign len_one   = count_one(len_cur);
    assign len_two   = count_one(len_one);
    assign len_first = count_one('{count: 8'd0, ovf: 1'b0});

    always_comb
    begin
        nxt            = cur;
        nxt.first_zero = 1'b0;
        emit           = 1'b0;
        cls            = CLS_ILLEGAL;
        unc            = UNC_ONE;
        unique case (cur.mode)
            MODE_HEX:
            begin
                if ((ch != CH_NUL) && is_hex(ch))
                begin
                    nxt.last_digit = 1'b1;
                    nxt.count      = len_one.count;
                    nxt.ovf        = len_one.ovf;
                end
                else
                begin
                    emit = 1'b1;
                    cls  = cur.last_digit ? CLS_HEX : CLS_ILLEGAL;
                end
            end
            MODE_SIGN:
            begin
                if (is_dec(ch))
                begin
                    nxt.mode       = MODE_EXP;
                    nxt.last_digit = 1'b1;
                    nxt.count      = len_two.count;
                    nxt.ovf        = len_two.ovf;
                end
                else
                begin
                    emit = 1'b1;
                    cls  = CLS_ILLEGAL;
                    unc  = UNC_TWO;
                end
            end
            MODE_INT, MODE_FRAC, MODE_EXPE, MODE_EXP:
            begin
                if ((cur.mode == MODE_INT) && cur.first_zero && (ch == CH_X))
                begin
                    nxt.mode       = MODE_HEX;
                    nxt.last_digit = 1'b0;
                    nxt.count      = len_one.count;
                    nxt.ovf        = len_one.ovf;
                end
                else if (ch == CH_DOT)
                begin
                    if (cur.mode != MODE_INT)
                    begin
                        emit = 1'b1;
                        cls  = CLS_ILLEGAL;
                    end
                    else
                    begin
                        nxt.mode       = MODE_FRAC;
                        nxt.last_digit = 1'b0;
                        nxt.count      = len_one.count;
                        nxt.ovf        = len_one.ovf;
                    end
                end
                else if (ch == CH_E)
                begin
                    if (cur.mode != MODE_FRAC)
                    begin
                        emit = 1'b1;
                        cls  = CLS_ILLEGAL;
                    end
                    else
                    begin
                        nxt.mode       = MODE_EXPE;
                        nxt.last_digit = 1'b0;
                        nxt.count      = len_one.count;
                        nxt.ovf        = len_one.ovf;
                    end
                end
                else if (is_dec(ch))
                begin
                    if (cur.mode == MODE_EXPE)
                    begin
                        nxt.mode = MODE_EXP;
                    end
                    nxt.last_digit = 1'b1;
                    nxt.count      = len_one.count;
                    nxt.ovf        = len_one.ovf;
                end
                else if ((cur.mode == MODE_EXPE) && ((ch == CH_PLUS) || (ch == CH_MINUS)))
                begin
                    nxt.mode = MODE_SIGN;
                end
                else
                begin
                    emit = 1'b1;
                    if (!cur.last_digit)
                    begin
                        cls = CLS_ILLEGAL;
                    end
                    else
                    begin
                        cls = (cur.mode == MODE_INT) ? CLS_INT : CLS_FLOAT;
                    end
                end
            end
            default:
            begin
                // idle, and unused mode codes treated as idle
                if (!is_dec(ch))
                begin
                    nxt  = '0;
                    emit = 1'b1;
                    cls  = CLS_NOTNUM;
                end
                else
                begin
                    nxt.mode       = MODE_INT;
                    nxt.first_zero = (ch == CH_ZERO);
                    nxt.last_digit = 1'b1;
                    nxt.count      = len_first.count;
                    nxt.ovf        = len_first.ovf;
                end
            end
        endcase

        res.token_class      = cls;
        res.token_length     = (emit && (cls == CLS_NOTNUM)) ? 8'd0 : cur.count;
        res.unconsumed       = unc;
        res.length_saturated = (emit && (cls == CLS_NOTNUM)) ? 1'b0 : cur.ovf;

        if (emit)
        begin
            nxt = '0;
        end
    end

endmodule

`default_nettype wire

// ----- src/nls_out_buf.sv -----
// ----------------------------------------------------------------------------
// nls_out_buf
// result register on the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module nls_out_buf (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire nls_pkg::token_result_t load_res,
    output logic                        can_load,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output nls_pkg::token_result_t      out_res
);
    import nls_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    token_result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the numeric literal scanner
//
// feeds source bytes on s_axis and checks every result word on m_axis
// against a cycle-free model of the scanner kept in the bench. a short
// table of hand-written tokens comes first, with the result typed in on
// each ending byte, then one over-long token and a random mix of integers,
// floats, hex literals, broken tokens and noise. both sides idle at random,
// and the receiver holds off once for a long stretch so the scanner stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nls_pkg::*;

    localparam int RANDOM_BYTES = 160;
    localparam int BURST_FROM   = 40;
    localparam int BURST_TO     = 100;
    localparam int LONG_DIGITS  = 258;
    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TABLE_ROWS   = 30;

    typedef struct packed {
        logic [7:0]    ch;
        logic          typed;
        token_result_t token;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    scan_mode_t    sc_mode;
    logic          sc_zero;
    logic          sc_digit;
    logic [7:0]    sc_len;
    logic          sc_sat;

    token_result_t pending_tokens[$];
    stim_row_t     directed_rows [TABLE_ROWS];
    int            mismatches;
    int            bytes_sent;
    int            tokens_seen;
    int            class_seen [5];
    int            longest_hold;
    int            idle_cycles;
    bit            sender_burst;

    numeric_literal_scanner_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex_char(input logic [7:0] c);
        return is_decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic void clear_scan();
        sc_mode  = MODE_IDLE;
        sc_zero  = 1'b0;
        sc_digit = 1'b0;
        sc_len   = 8'd0;
        sc_sat   = 1'b0;
    endfunction

    function automatic void bump_length();
        if (sc_len >= LEN_CAP)
        begin
            sc_sat = 1'b1;
        end
        else
        begin
            sc_len = sc_len + 8'd1;
        end
    endfunction

    function automatic token_result_t close_token(input token_class_t cls,
                                                  input logic [1:0] unc);
        token_result_t r;
        r.token_class      = cls;
        r.token_length     = sc_len;
        r.unconsumed       = unc;
        r.length_saturated = sc_sat;
        clear_scan();
        return r;
    endfunction

    function automatic void scan_byte(input logic [7:0] c, output bit fired,
                                      output token_result_t r);
        logic was_zero;
        was_zero = sc_zero;
        sc_zero  = 1'b0;
        fired    = 1'b0;
        r        = '0;
        case (sc_mode)
            MODE_IDLE:
            begin
                if (!is_decimal(c))
                begin
                    r = close_token(CLS_NOTNUM, UNC_ONE);
                    fired = 1'b1;
                end
                else
                begin
                    sc_mode  = MODE_INT;
                    sc_zero  = (c == CH_ZERO);
                    sc_digit = 1'b1;
                    bump_length();
                end
            end
            MODE_HEX:
            begin
                if (c != CH_NUL && is_hex_char(c))
                begin
                    sc_digit = 1'b1;
                    bump_length();
                end
                else
                begin
                    r = close_token(sc_digit ? CLS_HEX : CLS_ILLEGAL, UNC_ONE);
                    fired = 1'b1;
                end
            end
            MODE_SIGN:
            begin
                if (is_decimal(c))
                begin
                    bump_length();
                    bump_length();
                    sc_mode  = MODE_EXP;
                    sc_digit = 1'b1;
                end
                else
                begin
                    r = close_token(CLS_ILLEGAL, UNC_TWO);
                    fired = 1'b1;
                end
            end
            default:
            begin
                if (sc_mode == MODE_INT && was_zero && c == CH_X)
                begin
                    sc_mode  = MODE_HEX;
                    sc_digit = 1'b0;
                    bump_length();
                end
                else if (c == CH_DOT)
                begin
                    if (sc_mode != MODE_INT)
                    begin
                        r = close_token(CLS_ILLEGAL, UNC_ONE);
                        fired = 1'b1;
                    end
                    else
                    begin
                        sc_mode  = MODE_FRAC;
                        sc_digit = 1'b0;
                        bump_length();
                    end
                end
                else if (c == CH_E)
                begin
                    if (sc_mode != MODE_FRAC)
                    begin
                        r = close_token(CLS_ILLEGAL, UNC_ONE);
                        fired = 1'b1;
                    end
                    else
                    begin
                        sc_mode  = MODE_EXPE;
                        sc_digit = 1'b0;
                        bump_length();
                    end
                end
                else if (is_decimal(c))
                begin
                    if (sc_mode == MODE_EXPE)
                    begin
                        sc_mode = MODE_EXP;
                    end
                    sc_digit = 1'b1;
                    bump_length();
                end
                else if (sc_mode == MODE_EXPE && (c == CH_PLUS || c == CH_MINUS))
                begin
                    sc_mode = MODE_SIGN;
                end
                else if (!sc_digit)
                begin
                    r = close_token(CLS_ILLEGAL, UNC_ONE);
                    fired = 1'b1;
                end
                else
                begin
                    r = close_token(sc_mode == MODE_INT ? CLS_INT : CLS_FLOAT, UNC_ONE);
                    fired = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic stim_row_t mid(input logic [7:0] c);
        return '{c, 1'b0, '0};
    endfunction

    function automatic stim_row_t ends(input logic [7:0] c, input token_class_t cls,
                                       input logic [7:0] len, input logic [1:0] unc,
                                       input logic sat);
        return '{c, 1'b1, '{cls, len, unc, sat}};
    endfunction

    task automatic send_byte(input logic [7:0] c, input bit typed = 1'b0,
                             input token_result_t token = '0);
        int            gap;
        bit            fired;
        token_result_t r;
        gap = sender_burst ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        scan_byte(c, fired, r);
        if (typed)
        begin
            pending_tokens.push_back(token);
        end
        else if (fired)
        begin
            pending_tokens.push_back(r);
        end
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] rand_hex_digit();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
        begin
            return 8'(CH_ZERO + 8'(r));
        end
        if (r < 16)
        begin
            return 8'("a" + 8'(r - 10));
        end
        return 8'("A" + 8'(r - 16));
    endfunction

    task automatic send_digits(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n)
        begin
            send_byte(rand_digit());
        end
    endtask

    task automatic send_random_token();
        int    kind;
        int    n;
        int    sign;
        string pool;
        pool = "0123456789.ex+-";
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
            begin
                send_digits(1, 6);
            end
            3, 4, 5:
            begin
                send_digits(1, 3);
                send_byte(CH_DOT);
                send_digits(0, 3);
                if ($urandom_range(0, 2) != 0)
                begin
                    send_byte(CH_E);
                    sign = $urandom_range(0, 2);
                    if (sign == 1)
                    begin
                        send_byte(CH_PLUS);
                    end
                    else if (sign == 2)
                    begin
                        send_byte(CH_MINUS);
                    end
                    send_digits(0, 3);
                end
            end
            6, 7:
            begin
                send_byte(CH_ZERO);
                send_byte(CH_X);
                n = $urandom_range(0, 6);
                repeat (n)
                begin
                    send_byte(rand_hex_digit());
                end
            end
            8:
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_byte(8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        send_byte(pool[$urandom_range(0, pool.len() - 1)]);
                    end
                end
            end
            default:
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
        endcase
        if (kind <= 8)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic check_token(input logic [15:0] w);
        token_result_t want;
        token_result_t got;
        got.token_class      = token_class_t'(w[2:0]);
        got.token_length     = w[10:3];
        got.unconsumed       = w[12:11];
        got.length_saturated = w[13];
        tokens_seen++;
        if (int'(got.token_class) < 5)
        begin
            class_seen[int'(got.token_class)]++;
        end
        if (pending_tokens.size() == 0)
        begin
            $error("unexpected result word 0x%04h", w);
            mismatches++;
        end
        else
        begin
            want = pending_tokens.pop_front();
            if (got.token_class != want.token_class)
            begin
                $error("token_class expected %0d got %0d", want.token_class, got.token_class);
                mismatches++;
            end
            if (got.token_length != want.token_length)
            begin
                $error("token_length expected %0d got %0d", want.token_length,
                       got.token_length);
                mismatches++;
            end
            if (got.unconsumed != want.unconsumed)
            begin
                $error("unconsumed expected %0d got %0d", want.unconsumed, got.unconsumed);
                mismatches++;
            end
            if (got.length_saturated != want.length_saturated)
            begin
                $error("length_saturated expected %0d got %0d", want.length_saturated,
                       got.length_saturated);
                mismatches++;
            end
        end
    endtask

    // result side
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (tokens_seen == 10)
            begin
                stall = HOLD_CYCLES;
            end
            else if (tokens_seen >= 30 && tokens_seen < 60)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 3);
            end
            if (stall > longest_hold)
            begin
                longest_hold = stall;
            end
            repeat (stall)
            begin
                m_axis_tready <= 1'b0;
                @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            check_token(m_axis_tdata);
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d cycles without a word", idle_cycles);
                $display("status: fail");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // byte side and run control
    initial
    begin
        int start_count;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        rst_n         <= 1'b0;
        mismatches    = 0;
        bytes_sent    = 0;
        tokens_seen   = 0;
        longest_hold  = 0;
        sender_burst  = 1'b0;
        class_seen    = '{default: 0};
        clear_scan();

        directed_rows = '{
            ends(CH_NUL, CLS_NOTNUM, 8'd0, UNC_ONE, 1'b0),
            mid(CH_ZERO), mid(CH_X),
            ends("g", CLS_ILLEGAL, 8'd2, UNC_ONE, 1'b0),
            mid(CH_ZERO), mid(CH_X), mid("a"), mid("F"),
            ends(CH_NUL, CLS_HEX, 8'd4, UNC_ONE, 1'b0),
            mid("1"), mid(CH_DOT), mid("5"), mid(CH_E), mid(CH_MINUS),
            ends("z", CLS_ILLEGAL, 8'd4, UNC_TWO, 1'b0),
            mid("1"), mid(CH_DOT), mid("2"),
            ends(CH_DOT, CLS_ILLEGAL, 8'd3, UNC_ONE, 1'b0),
            mid("7"),
            ends(CH_E, CLS_ILLEGAL, 8'd1, UNC_ONE, 1'b0),
            mid("3"), mid(CH_DOT), mid("5"), mid(CH_E), mid(CH_PLUS), mid("9"),
            ends(8'hFF, CLS_FLOAT, 8'd6, UNC_ONE, 1'b0),
            mid("8"),
            ends(",", CLS_INT, 8'd1, UNC_ONE, 1'b0)
        };

        repeat (7)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].token);
        end

        // token longer than the length counter holds
        send_byte("1");
        repeat (LONG_DIGITS - 1)
        begin
            send_byte(rand_digit());
        end
        send_byte(" ");

        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES)
        begin
            sender_burst = (bytes_sent - start_count >= BURST_FROM &&
                            bytes_sent - start_count < BURST_TO);
            send_random_token();
        end
        sender_burst = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_tokens.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        $display("sent %0d bytes, checked %0d results, longest receiver hold %0d cycles",
                 bytes_sent, tokens_seen, longest_hold);
        $display("classes int %0d float %0d hex %0d illegal %0d not-a-number %0d",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4]);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
